// ===== src/speed_limited_move_to_target_unit_defines.svh =====
// ----------------------------------------------------------------------------
// speed limited move to target: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SPEED_LIMITED_MOVE_TO_TARGET_UNIT_DEFINES_SVH
`define SPEED_LIMITED_MOVE_TO_TARGET_UNIT_DEFINES_SVH

// same-cycle implication
`define SLMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/slmt_pkg.sv =====
// ----------------------------------------------------------------------------
// slmt_pkg
// types and constants shared by the move-to-target controller and datapath
// ----------------------------------------------------------------------------
package slmt_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_SPEED = 3'd0;
  localparam logic [2:0] CFG_SNAP      = 3'd1;
  localparam logic [2:0] CFG_START_X   = 3'd2;
  localparam logic [2:0] CFG_START_Y   = 3'd3;
  localparam logic [2:0] CFG_START_Z   = 3'd4;

  localparam logic [23:0] MAX_SPEED_RST = 24'd65536;
  localparam logic [15:0] SNAP_RST      = 16'd655;
  localparam logic [10:0] MIN_PAYLOAD   = 11'd12;

  // input kinds
  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_SET_TGT,
    DP_LOAD,
    DP_SQ,
    DP_ACC,
    DP_SQRT,
    DP_DIST,
    DP_SPD,
    DP_CLAMP,
    DP_VMUL,
    DP_VDIV,
    DP_SMUL,
    DP_POS,
    DP_SNAP,
    DP_OUT
  } slmt_op_e;

  // shared engine modes
  typedef enum logic [1:0] {
    ENG_MUL,
    ENG_DIV,
    ENG_SQRT
  } slmt_eng_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_CHK,
    ST_SPD,
    ST_VMUL,
    ST_VDIV,
    ST_SMUL,
    ST_OUT
  } slmt_state_e;

  typedef struct packed {
    slmt_op_e   op;
    logic [1:0] idx;
  } slmt_cmd_t;

  typedef struct packed {
    logic busy;
    logic far;
    logic out_full;
  } slmt_sts_t;

endpackage

// ===== src/speed_limited_move_to_target_unit.sv =====
// a target update or a zero-time tick starts no work; s_axis_tready_o stays high
// a moving tick goes through the shared bit-serial multiply/divide/root engine
// before its word shows on the output: 3 squares, a 34-step root, then, unless
// within the snap distance, a speed divide and per axis a multiply, a divide and
// a step multiply, one bit per cycle
// async active-low reset: position, target, velocity zero; limits to defaults
// ----------------------------------------------------------------------------
// speed_limited_move_to_target_unit
// moves a 3d fixed-point position toward a target under a speed limit
// ----------------------------------------------------------------------------
module speed_limited_move_to_target_unit import slmt_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // payload_bytes, coord_x, coord_y, coord_z, elapsed_time, zero fill
  input  logic [135:0] s_axis_tdata_i,
  // kind
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic [191:0] m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  slmt_cmd_t   cmd;
  slmt_sts_t   sts;
  logic [10:0] payload_bytes;
  logic [23:0] elapsed_time;
  logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;

  // input word decode
  assign payload_bytes = s_axis_tdata_i[10:0];
  assign elapsed_time  = s_axis_tdata_i[130:107];

  slmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_kind_i   (s_axis_tuser_i),
    .in_plen_ok_i(payload_bytes >= MIN_PAYLOAD),
    .in_dt_zero_i(elapsed_time == '0),
    .in_ready_o  (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slmt_datapath #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .coord_x_i     (s_axis_tdata_i[42:11]),
    .coord_y_i     (s_axis_tdata_i[74:43]),
    .coord_z_i     (s_axis_tdata_i[106:75]),
    .elapsed_time_i(elapsed_time),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .pos_z_o       (pos_z),
    .vel_x_o       (vel_x),
    .vel_y_o       (vel_y),
    .vel_z_o       (vel_z)
  );

  // output word packing
  assign m_axis_tdata_o = {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};

endmodule

// ===== src/slmt_datapath.sv =====
// ----------------------------------------------------------------------------
// slmt_datapath
// state registers, shared bit-serial multiply/divide/root engine, output word
// ----------------------------------------------------------------------------
module slmt_datapath import slmt_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slmt_cmd_t          cmd_i,
  output slmt_sts_t          sts_o,
  input  logic        [31:0] coord_x_i,
  input  logic        [31:0] coord_y_i,
  input  logic        [31:0] coord_z_i,
  input  logic        [23:0] elapsed_time_i,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [31:0] cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic        [31:0] pos_x_o,
  output logic        [31:0] pos_y_o,
  output logic        [31:0] pos_z_o,
  output logic        [31:0] vel_x_o,
  output logic        [31:0] vel_y_o,
  output logic        [31:0] vel_z_o
);

  localparam int F    = COORD_FRAC_BITS;
  localparam int DivW = (F + 34 > 57) ? F + 34 : 57;
  localparam int AW   = 68;
  localparam int CntW = 6;
  localparam int SumW = 50;
  localparam logic [CntW-1:0] MulIter  = CntW'(33);
  localparam logic [CntW-1:0] DivIter  = CntW'(DivW);
  localparam logic [CntW-1:0] SqrtIter = CntW'(34);

  logic [31:0]     pos_q [3];
  logic [31:0]     tgt_q [3];
  logic [31:0]     vel_q [3];
  logic [32:0]     mag_q [3];
  logic [2:0]      neg_q;
  logic [23:0]     dt_q;
  logic [AW-1:0]   acc_q;
  logic [33:0]     dist_q;
  logic [23:0]     speed_q;
  logic [23:0]     max_speed_q;
  logic [15:0]     snap_q;
  slmt_eng_e       mode_q;
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [AW-1:0]   a_q;
  logic [33:0]     b_q;
  logic [AW-1:0]   r_q;
  logic [DivW-1:0] q_q;
  logic            out_valid_q;
  logic [31:0]     out_pos_q [3];
  logic [31:0]     out_vel_q [3];

  logic [31:0]     coord [3];
  logic [32:0]     diff  [3];
  logic [32:0]     magd  [3];
  logic [AW-1:0]   mul_sum;
  logic [34:0]     div_sh;
  logic [34:0]     div_diff;
  logic            div_ge;
  logic [36:0]     sq_sh;
  logic [36:0]     sq_trial;
  logic [36:0]     sq_diff;
  logic            sq_ge;
  logic [SumW-1:0] step;
  logic [SumW-1:0] psum;
  logic [31:0]     psat;
  logic [31:0]     vm;
  logic [1:0]      k;

  assign k     = cmd_i.idx;
  assign coord = '{coord_x_i, coord_y_i, coord_z_i};

  // per-axis difference and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {tgt_q[i][31], tgt_q[i]} - {pos_q[i][31], pos_q[i]};
      magd[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
    end
  end

  // one engine step
  always_comb begin
    mul_sum  = r_q + (b_q[0] ? a_q : '0);
    div_sh   = {r_q[33:0], a_q[DivW-1]};
    div_ge   = div_sh >= {1'b0, b_q};
    div_diff = div_sh - {1'b0, b_q};
    sq_sh    = {r_q[34:0], a_q[AW-1:AW-2]};
    sq_trial = {1'b0, q_q[33:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_diff  = sq_sh - sq_trial;
  end

  // position step with saturation
  always_comb begin
    step = SumW'(r_q[47:0] >> F);
    psum = neg_q[k] ? ({{(SumW-32){pos_q[k][31]}}, pos_q[k]} - step)
                    : ({{(SumW-32){pos_q[k][31]}}, pos_q[k]} + step);
    if (!psum[SumW-1] && (psum[SumW-2:31] != '0)) begin
      psat = 32'h7fff_ffff;
    end else if (psum[SumW-1] && (psum[SumW-2:31] != '1)) begin
      psat = 32'h8000_0000;
    end else begin
      psat = psum[31:0];
    end
    vm = {8'd0, q_q[23:0]};
  end

  // architectural state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        tgt_q[i] <= '0;
        vel_q[i] <= '0;
      end
      max_speed_q <= MAX_SPEED_RST;
      snap_q      <= SNAP_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_SPEED: max_speed_q <= cfg_data_i[23:0];
          CFG_SNAP:      snap_q      <= cfg_data_i[15:0];
          CFG_START_X: begin
            pos_q[0] <= cfg_data_i;
            tgt_q[0] <= cfg_data_i;
          end
          CFG_START_Y: begin
            pos_q[1] <= cfg_data_i;
            tgt_q[1] <= cfg_data_i;
          end
          CFG_START_Z: begin
            pos_q[2] <= cfg_data_i;
            tgt_q[2] <= cfg_data_i;
          end
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        DP_SET_TGT: tgt_q <= coord;
        DP_SMUL:    vel_q[k] <= neg_q[k] ? (32'd0 - vm) : vm;
        DP_POS:     pos_q[k] <= psat;
        DP_SNAP: begin
          pos_q <= tgt_q;
          for (int i = 0; i < 3; i++) vel_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  // engine control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      mode_q      <= ENG_MUL;
      out_valid_q <= 1'b0;
    end else begin
      if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) busy_q <= 1'b0;
      end
      unique case (cmd_i.op)
        DP_SQ, DP_VMUL, DP_SMUL: begin
          busy_q <= 1'b1;
          cnt_q  <= MulIter;
          mode_q <= ENG_MUL;
        end
        DP_SPD, DP_VDIV: begin
          busy_q <= 1'b1;
          cnt_q  <= DivIter;
          mode_q <= ENG_DIV;
        end
        DP_SQRT: begin
          busy_q <= 1'b1;
          cnt_q  <= SqrtIter;
          mode_q <= ENG_SQRT;
        end
        default: ;
      endcase
      if (cmd_i.op == DP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // engine operands and working values
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      unique case (mode_q)
        ENG_MUL: begin
          r_q <= mul_sum;
          a_q <= a_q << 1;
          b_q <= b_q >> 1;
        end
        ENG_DIV: begin
          r_q <= AW'(div_ge ? div_diff : div_sh);
          q_q <= {q_q[DivW-2:0], div_ge};
          a_q <= a_q << 1;
        end
        ENG_SQRT: begin
          r_q <= AW'(sq_ge ? sq_diff : sq_sh);
          q_q <= {q_q[DivW-2:0], sq_ge};
          a_q <= a_q << 2;
        end
        default: ;
      endcase
    end
    unique case (cmd_i.op)
      DP_LOAD: begin
        dt_q  <= elapsed_time_i;
        acc_q <= '0;
        mag_q <= magd;
        for (int i = 0; i < 3; i++) neg_q[i] <= diff[i][32];
      end
      DP_SQ: begin
        a_q <= AW'(mag_q[k]);
        b_q <= 34'(mag_q[k]);
        r_q <= '0;
      end
      DP_ACC:  acc_q <= acc_q + r_q;
      DP_SQRT: begin
        a_q <= acc_q;
        r_q <= '0;
        q_q <= '0;
      end
      DP_DIST: dist_q <= q_q[33:0];
      DP_SPD: begin
        a_q <= AW'(dist_q) << F;
        b_q <= 34'(dt_q);
        r_q <= '0;
        q_q <= '0;
      end
      DP_CLAMP: speed_q <= (q_q > DivW'(max_speed_q)) ? max_speed_q : q_q[23:0];
      DP_VMUL: begin
        a_q <= AW'(mag_q[k]);
        b_q <= 34'(speed_q);
        r_q <= '0;
      end
      DP_VDIV: begin
        a_q <= AW'(r_q[56:0]);
        b_q <= dist_q;
        r_q <= '0;
        q_q <= '0;
      end
      DP_SMUL: begin
        a_q <= AW'(q_q[23:0]);
        b_q <= 34'(dt_q);
        r_q <= '0;
      end
      DP_OUT: begin
        out_pos_q <= pos_q;
        out_vel_q <= vel_q;
      end
      default: ;
    endcase
  end

  // status and outputs
  assign sts_o.busy     = busy_q;
  assign sts_o.far      = dist_q > 34'(snap_q);
  assign sts_o.out_full = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_pos_q[0];
  assign pos_y_o     = out_pos_q[1];
  assign pos_z_o     = out_pos_q[2];
  assign vel_x_o     = out_vel_q[0];
  assign vel_y_o     = out_vel_q[1];
  assign vel_z_o     = out_vel_q[2];

endmodule

// ===== src/slmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// slmt_ctrl
// sequencer that takes input words and steps the datapath through one tick
// ----------------------------------------------------------------------------
module slmt_ctrl import slmt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  input  logic      in_plen_ok_i,
  input  logic      in_dt_zero_i,
  output logic      in_ready_o,
  input  slmt_sts_t sts_i,
  output slmt_cmd_t cmd_o
);

  slmt_state_e state_q, state_d;
  logic        ph_q, ph_d;
  logic [1:0]  k_q, k_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      k_q     <= k_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    k_d        = k_q;
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.idx  = k_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_TARGET) begin
            if (in_plen_ok_i) cmd_o.op = DP_SET_TGT;
          end else if (!in_dt_zero_i) begin
            cmd_o.op = DP_LOAD;
            k_d      = '0;
            ph_d     = 1'b0;
            state_d  = ST_SQ;
          end
        end
      end
      // sum of squares, one axis at a time
      ST_SQ: begin
        if (!ph_q) begin
          cmd_o.op = DP_SQ;
          ph_d     = 1'b1;
        end else if (!sts_i.busy) begin
          cmd_o.op = DP_ACC;
          ph_d     = 1'b0;
          if (k_q == 2'd2) begin
            k_d     = '0;
            state_d = ST_SQRT;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      ST_SQRT: begin
        if (!ph_q) begin
          cmd_o.op = DP_SQRT;
          ph_d     = 1'b1;
        end else if (!sts_i.busy) begin
          cmd_o.op = DP_DIST;
          ph_d     = 1'b0;
          state_d  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.far) begin
          state_d = ST_SPD;
        end else begin
          cmd_o.op = DP_SNAP;
          state_d  = ST_OUT;
        end
      end
      ST_SPD: begin
        if (!ph_q) begin
          cmd_o.op = DP_SPD;
          ph_d     = 1'b1;
        end else if (!sts_i.busy) begin
          cmd_o.op = DP_CLAMP;
          ph_d     = 1'b0;
          state_d  = ST_VMUL;
        end
      end
      ST_VMUL: begin
        if (!ph_q) begin
          cmd_o.op = DP_VMUL;
          ph_d     = 1'b1;
        end else if (!sts_i.busy) begin
          ph_d    = 1'b0;
          state_d = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (!ph_q) begin
          cmd_o.op = DP_VDIV;
          ph_d     = 1'b1;
        end else if (!sts_i.busy) begin
          ph_d    = 1'b0;
          state_d = ST_SMUL;
        end
      end
      // velocity is written as the step multiply starts
      ST_SMUL: begin
        if (!ph_q) begin
          cmd_o.op = DP_SMUL;
          ph_d     = 1'b1;
        end else if (!sts_i.busy) begin
          cmd_o.op = DP_POS;
          ph_d     = 1'b0;
          if (k_q == 2'd2) begin
            k_d     = '0;
            state_d = ST_OUT;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_VMUL;
          end
        end
      end
      ST_OUT: begin
        if (!sts_i.out_full) begin
          cmd_o.op = DP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/slmt_checker.sv =====
// ----------------------------------------------------------------------------
// slmt_checker
// port-level checks for the move-to-target unit, bound to the top level
// ----------------------------------------------------------------------------
`include "speed_limited_move_to_target_unit_defines.svh"

module slmt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [135:0] s_axis_tdata_i,
  input logic         s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i
);

  logic in_acc;

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  // an output word waits until taken
  `SLMT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "output word dropped")
  // a target update never starts work
  `SLMT_ASSERT_NEXT(a_tgt_ready, in_acc && !s_axis_tuser_i, s_axis_tready_o, "busy after target update")
  // a zero-time tick never starts work
  `SLMT_ASSERT_NEXT(a_zero_ready, in_acc && s_axis_tuser_i && (s_axis_tdata_i[130:107] == 24'd0), s_axis_tready_o, "busy after zero tick")
  // no result can appear right after an accepted item
  `SLMT_ASSERT_NEXT(a_no_fast_out, in_acc, !$rose(m_axis_tvalid_o), "result too early")

endmodule

bind speed_limited_move_to_target_unit slmt_checker u_slmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: speed limited move to target unit testbench
// drives target and tick words through the input stream under random bursts,
// predicts every non-zero-time tick's position and velocity word in a scoreboard
// and compares each output word field by field across several register sets
// ----------------------------------------------------------------------------

// scoreboard: own copy of the motion state and the expected output words
class motion_scoreboard;
  logic [23:0] max_speed;
  logic [15:0] snap_dist;
  longint      pos [3];
  longint      tgt [3];
  longint      vel [3];
  logic [191:0] expected_words [$];
  int mismatches;
  int words_checked;
  int snaps;
  int moves;

  function new();
    max_speed = slmt_pkg::MAX_SPEED_RST;
    snap_dist = slmt_pkg::SNAP_RST;
    for (int k = 0; k < 3; k++) begin
      pos[k] = 0;
      tgt[k] = 0;
      vel[k] = 0;
    end
    mismatches = 0;
    words_checked = 0;
    snaps = 0;
    moves = 0;
  endfunction

  // register write, mirrored into the predicted state
  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      slmt_pkg::CFG_MAX_SPEED: max_speed = data[23:0];
      slmt_pkg::CFG_SNAP:      snap_dist = data[15:0];
      slmt_pkg::CFG_START_X: begin
        pos[0] = longint'($signed(data));
        tgt[0] = pos[0];
      end
      slmt_pkg::CFG_START_Y: begin
        pos[1] = longint'($signed(data));
        tgt[1] = pos[1];
      end
      slmt_pkg::CFG_START_Z: begin
        pos[2] = longint'($signed(data));
        tgt[2] = pos[2];
      end
      default: ;
    endcase
  endfunction

  // floor square root, digit by digit
  function logic [63:0] floor_root(logic [67:0] v);
    logic [71:0] rem;
    logic [71:0] trial;
    logic [63:0] root;
    rem = 0;
    root = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 72'(v[2*i +: 2]);
      trial = (72'(root) << 2) | 72'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function longint sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  // accepted input word: update state and queue the expected output
  function void note_input(logic kind, logic [10:0] plen, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] cz, logic [23:0] dt);
    longint      d [3];
    logic [63:0] m [3];
    logic [67:0] sum;
    logic [63:0] span;
    logic [63:0] speed;
    logic [63:0] vm;
    logic [63:0] step;
    logic [191:0] w;
    if (kind == slmt_pkg::KIND_TARGET) begin
      if (plen >= slmt_pkg::MIN_PAYLOAD) begin
        tgt[0] = longint'($signed(cx));
        tgt[1] = longint'($signed(cy));
        tgt[2] = longint'($signed(cz));
      end
      return;
    end
    if (dt == 0) return;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = tgt[k] - pos[k];
      m[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
      sum = sum + 68'(m[k] * m[k]);
    end
    span = floor_root(sum);
    if (span > 64'(snap_dist)) begin
      moves++;
      speed = (span << 16) / 64'(dt);
      if (speed > 64'(max_speed)) speed = 64'(max_speed);
      for (int k = 0; k < 3; k++) begin
        vm = m[k] * speed / span;
        step = (vm * 64'(dt)) >> 16;
        vel[k] = (d[k] < 0) ? -longint'(vm) : longint'(vm);
        pos[k] = sat32((d[k] < 0) ? pos[k] - longint'(step) : pos[k] + longint'(step));
      end
    end else begin
      snaps++;
      for (int k = 0; k < 3; k++) begin
        pos[k] = tgt[k];
        vel[k] = 0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      w[32*k +: 32] = pos[k][31:0];
      w[96 + 32*k +: 32] = vel[k][31:0];
    end
    expected_words.push_back(w);
  endfunction

  // accepted output word against the oldest expectation
  function void check_word(logic [191:0] got);
    logic [191:0] want;
    bit bad;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output word %h", got);
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    bad = 0;
    for (int f = 0; f < 6; f++)
      if (got[32*f +: 32] !== want[32*f +: 32]) bad = 1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        for (int f = 0; f < 6; f++)
          if (got[32*f +: 32] !== want[32*f +: 32])
            $display("word %0d field %0d: expected %h actual %h",
                     words_checked, f, want[32*f +: 32], got[32*f +: 32]);
    end
  endfunction
endclass

module tb_top;
  import slmt_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [191:0] m_axis_tdata_o;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;

  motion_scoreboard sb;
  int  burst_left;
  int  items_sent;
  int  ticks_sent;
  bit  long_hold_req;

  speed_limited_move_to_target_unit uut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  // one register write
  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one word, with burst gaps, until accepted
  task automatic send_word(logic kind, logic [10:0] plen, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] cz, logic [23:0] dt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {5'd0, dt, cz, cy, cx, plen};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(kind, plen, cx, cy, cz, dt);
    items_sent++;
    if (kind == KIND_TICK) ticks_sent++;
  endtask

  // lower valid, wait out every expected word plus the tick latency
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  // random word: mostly good targets and ticks, some near targets and noise
  task automatic random_word();
    int sel;
    logic [31:0] c [3];
    logic [23:0] dt;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      for (int k = 0; k < 3; k++) c[k] = $urandom();
      send_word(KIND_TARGET, 11'($urandom_range(12, 1024)), c[0], c[1], c[2], 24'd0);
    end else if (sel < 45) begin
      // target close to the current position
      for (int k = 0; k < 3; k++)
        c[k] = sb.pos[k][31:0] + 32'($signed($urandom_range(0, 4000)) - 2000);
      send_word(KIND_TARGET, 11'($urandom_range(12, 1024)), c[0], c[1], c[2], 24'd0);
    end else if (sel < 50) begin
      for (int k = 0; k < 3; k++) c[k] = $urandom();
      send_word(KIND_TARGET, 11'($urandom_range(0, 11)), c[0], c[1], c[2], 24'($urandom()));
    end else begin
      case ($urandom_range(0, 3))
        0: dt = 24'($urandom());
        1: dt = 24'($urandom_range(1, 255));
        2: dt = 24'($urandom_range(1, 131072));
        default: dt = (sel < 53) ? 24'd0 : 24'($urandom_range(1, 8192));
      endcase
      send_word(KIND_TICK, 11'($urandom()), $urandom(), $urandom(), $urandom(), dt);
    end
  endtask

  // receiver: checks accepted words and stalls on its own pattern
  initial begin
    int mode_left;
    int mode;
    int hold_left;
    int phase;
    m_axis_tready_i = 1'b0;
    mode_left = 0;
    mode = 0;
    hold_left = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 2000);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i <= (phase % 7) < 3;
        endcase
      end
    end
  end

  // stimulus
  initial begin
    logic [23:0] speeds [4];
    logic [15:0] snaps [4];
    sb = new();
    burst_left = 0;
    items_sent = 0;
    ticks_sent = 0;
    long_hold_req = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed words at reset settings
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd1);          // zero distance snap
    send_word(KIND_TICK, 11'd2047, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'd0);
    send_word(KIND_TARGET, 11'd11, 32'h7FFFFFFF, 32'd5, 32'd5, 24'hFFFFFF);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd65536);      // still at target
    send_word(KIND_TARGET, 11'd12, 32'd400, 32'd200, 32'd100, 24'd0); // within snap
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'hFFFFFF);
    send_word(KIND_TARGET, 11'd1024, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 24'd0);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd1);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'hFFFFFF);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd65536);
    send_word(KIND_TARGET, 11'd0, 32'd0, 32'd0, 32'd0, 24'd0);
    send_word(KIND_TICK, 11'd5, 32'd0, 32'd0, 32'd0, 24'd1000);
    drain();

    // opposite corners with extreme limits
    cfg_write(CFG_MAX_SPEED, 32'h00FFFFFF);
    cfg_write(CFG_SNAP, 32'd0);
    cfg_write(CFG_START_X, 32'h80000000);
    cfg_write(CFG_START_Y, 32'h7FFFFFFF);
    cfg_write(CFG_START_Z, 32'h80000000);
    cfg_write(3'd5, 32'hFFFFFFFF);
    cfg_write(3'd7, 32'h12345678);
    send_word(KIND_TARGET, 11'd12, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 24'd0);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'hFFFFFF);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd1);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd3);
    drain();
    cfg_write(CFG_MAX_SPEED, 32'd0);
    cfg_write(CFG_SNAP, 32'h0000FFFF);
    send_word(KIND_TARGET, 11'd20, 32'd0, 32'd0, 32'd0, 24'd0);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd100);
    send_word(KIND_TARGET, 11'd20, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'd0);
    send_word(KIND_TICK, 11'd0, 32'd0, 32'd0, 32'd0, 24'd100);
    drain();

    // random phases over several register sets
    speeds = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd0};
    snaps  = '{16'd655, 16'd0, 16'hFFFF, 16'd0};
    for (int p = 0; p < 8; p++) begin
      if (p < 4) begin
        cfg_write(CFG_MAX_SPEED, 32'(speeds[p]));
        cfg_write(CFG_SNAP, 32'(snaps[p]));
      end else begin
        cfg_write(CFG_MAX_SPEED, $urandom());
        cfg_write(CFG_SNAP, $urandom());
      end
      cfg_write(CFG_START_X, $urandom());
      cfg_write(CFG_START_Y, $urandom());
      cfg_write(CFG_START_Z, $urandom());
      for (int i = 0; i < 165; i++) begin
        // long receiver hold while words keep coming
        if (i == 40 && (p % 2) == 0) long_hold_req = 1;
        // sender pause until the output has caught up
        if (i == 100) begin
          s_axis_tvalid_i <= 1'b0;
          burst_left = 0;
          while (sb.expected_words.size() != 0) @(posedge clk_i);
        end
        random_word();
      end
      drain();
    end

    $display("sent %0d words (%0d ticks) across 11 register settings",
             items_sent, ticks_sent);
    $display("checked %0d output words: %0d moves, %0d snaps",
             sb.words_checked, sb.moves, sb.snaps);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
